// File: sv/setl_pkg.sv
// Shared types and constants for the sorted event timeline.
`timescale 1ns / 1ps

package setl_pkg;

   // Request selector codes carried on req_tuser
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_SEEK   = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   // Stream and register widths
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;
   localparam int OUT_CNT_W  = 7;
   localparam int CAP_W      = 7;
   localparam int IDX_W      = 6;

   // One stored event
   typedef struct packed {
      logic signed [31:0] ev_time;
      logic [1:0]         ev_kind;
      logic [7:0]         ev_arg;
      logic signed [31:0] ev_value;
   } setl_entry_type;

endpackage

// File: sv/sorted_event_timeline_top.sv
// Top level of the sorted event timeline: sequencer, counters and stream ports.
`timescale 1ns / 1ps

// Channel   Ports                       tdata / tuser contents
// req       req_tvalid/tready/tdata/    tdata: time, kind, arg, value, read index
//           req_tuser                   tuser: action
// rsp       rsp_tvalid/tready/tdata/    tdata: count, cursor, entry fields
//           rsp_tuser                   tuser: stored, entry_valid
// csr       csr_wr_en/csr_wr_data       capacity limit, written at once
//
// Timing: one compare against the store per cycle, through the single read port.
// Insert examines stored entries one by one from the tail, with a final write
// step when the event lands at the front; seek scans entries from the head;
// read looks the entry up, or answers on acceptance when the index is out of range;
// drops and unused actions answer on acceptance.
// Reset clears count, cursor, limit and the result valid flag; the store is not
// cleared. A waiting result blocks the next request until it is transferred.

module sorted_event_timeline_top #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // time[31:0], kind[33:32], arg[41:34], value[73:42], read_index[79:74]
   input  logic [setl_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action[1:0]
   input  logic [1:0]                        req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // event_count[6:0], cursor_position[13:7], entry_time[45:14],
   // entry_kind[47:46], entry_arg[55:48], entry_value[87:56]
   output logic [setl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // stored[0], entry_valid[1]
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wr_en,
   input  logic [setl_pkg::CAP_W-1:0]        csr_wr_data
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int LW    = (CNT_W > setl_pkg::CAP_W) ? CNT_W : setl_pkg::CAP_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_SEEK,
      ST_READ
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         held_count_ff, held_count_in;
   logic [CNT_W-1:0]         cursor_ff, cursor_in;
   logic [setl_pkg::CAP_W-1:0] cap_ff;
   logic [AW-1:0]            cmp_idx_ff, cmp_idx_in;
   setl_pkg::setl_entry_type new_ff, new_in;

   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic                     rsp_stored_ff, rsp_stored_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [setl_pkg::OUT_CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [setl_pkg::OUT_CNT_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   setl_pkg::setl_entry_type rsp_entry_ff, rsp_entry_in;

   // Store port
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   setl_pkg::setl_entry_type mem_wdata;
   logic [AW-1:0]            mem_raddr;
   setl_pkg::setl_entry_type mem_rdata;

   // Request fields
   logic [1:0]                     req_action;
   setl_pkg::setl_entry_type       req_entry;
   logic [setl_pkg::IDX_W-1:0]     req_index;
   logic                           req_xfer;

   // Completion of the current request
   logic                     done;
   logic                     done_stored;
   logic                     done_valid;
   setl_pkg::setl_entry_type done_entry;

   // Capacity and range checks
   logic [LW-1:0]            cap_w;
   logic [LW-1:0]            limit_w;
   logic                     store_full;
   logic                     index_in_range;

   assign req_action         = req_tuser;
   assign req_entry.ev_time  = req_tdata[31:0];
   assign req_entry.ev_kind  = req_tdata[33:32];
   assign req_entry.ev_arg   = req_tdata[41:34];
   assign req_entry.ev_value = req_tdata[73:42];
   assign req_index          = req_tdata[79:74];

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_tvalid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;

   assign cap_w      = LW'(cap_ff);
   assign limit_w    = ((cap_w == '0) || (cap_w > LW'(DEPTH))) ? LW'(DEPTH) : cap_w;
   assign store_full = LW'(held_count_ff) >= limit_w;
   assign index_in_range = LW'(req_index) < LW'(held_count_ff);

   setl_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Sequence one request over the store
   always_comb begin
      state_in      = state_ff;
      held_count_in = held_count_ff;
      cursor_in     = cursor_ff;
      cmp_idx_in    = cmp_idx_ff;
      new_in        = new_ff;
      mem_we        = 1'b0;
      mem_waddr     = cmp_idx_ff + AW'(1);
      mem_wdata     = new_ff;
      mem_raddr     = cmp_idx_ff;
      done          = 1'b0;
      done_stored   = 1'b0;
      done_valid    = 1'b0;
      done_entry    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               new_in = req_entry;
               unique case (req_action)
                  setl_pkg::ACT_INSERT: begin
                     if (store_full) begin
                        done = 1'b1;
                     end else if (held_count_ff == '0) begin
                        mem_we        = 1'b1;
                        mem_waddr     = '0;
                        mem_wdata     = req_entry;
                        held_count_in = held_count_ff + CNT_W'(1);
                        done          = 1'b1;
                        done_stored   = 1'b1;
                     end else begin
                        mem_raddr  = AW'(held_count_ff - CNT_W'(1));
                        cmp_idx_in = AW'(held_count_ff - CNT_W'(1));
                        state_in   = ST_SHIFT;
                     end
                  end
                  setl_pkg::ACT_SEEK: begin
                     if (held_count_ff == '0) begin
                        cursor_in = '0;
                        done      = 1'b1;
                     end else begin
                        mem_raddr  = '0;
                        cmp_idx_in = '0;
                        state_in   = ST_SEEK;
                     end
                  end
                  setl_pkg::ACT_READ: begin
                     if (index_in_range) begin
                        mem_raddr = AW'(req_index);
                        state_in  = ST_READ;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // Move a later entry up one slot, or drop the new event in behind it
            mem_we    = 1'b1;
            mem_waddr = cmp_idx_ff + AW'(1);
            if (mem_rdata.ev_time > new_ff.ev_time) begin
               mem_wdata = mem_rdata;
               if (cmp_idx_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  cmp_idx_in = cmp_idx_ff - AW'(1);
                  mem_raddr  = cmp_idx_ff - AW'(1);
               end
            end else begin
               mem_wdata     = new_ff;
               held_count_in = held_count_ff + CNT_W'(1);
               done          = 1'b1;
               done_stored   = 1'b1;
            end
         end
         ST_PLACE: begin
            mem_we        = 1'b1;
            mem_waddr     = '0;
            mem_wdata     = new_ff;
            held_count_in = held_count_ff + CNT_W'(1);
            done          = 1'b1;
            done_stored   = 1'b1;
         end
         ST_SEEK: begin
            // Advance while stored times lie strictly before the target
            if (mem_rdata.ev_time < new_ff.ev_time) begin
               if (CNT_W'(cmp_idx_ff) + CNT_W'(1) == held_count_ff) begin
                  cursor_in = held_count_ff;
                  done      = 1'b1;
               end else begin
                  cmp_idx_in = cmp_idx_ff + AW'(1);
                  mem_raddr  = cmp_idx_ff + AW'(1);
               end
            end else begin
               cursor_in = CNT_W'(cmp_idx_ff);
               done      = 1'b1;
            end
         end
         ST_READ: begin
            done       = 1'b1;
            done_valid = 1'b1;
            done_entry = mem_rdata;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         state_in = ST_IDLE;
      end
   end

   // Load the result register on completion, release it on transfer
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_stored_in = rsp_stored_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_entry_in  = rsp_entry_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (done) begin
         rsp_tvalid_in = 1'b1;
         rsp_stored_in = done_stored;
         rsp_valid_in  = done_valid;
         rsp_count_in  = setl_pkg::OUT_CNT_W'(held_count_in);
         rsp_cursor_in = setl_pkg::OUT_CNT_W'(cursor_in);
         rsp_entry_in  = done_entry;
      end
   end

   // Hold state, counters and the registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_count_ff <= '0;
         cursor_ff     <= '0;
         cap_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         cursor_ff     <= cursor_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
      cmp_idx_ff    <= cmp_idx_in;
      new_ff        <= new_in;
      rsp_stored_ff <= rsp_stored_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = {rsp_valid_ff, rsp_stored_ff};
   assign rsp_tdata  = {rsp_entry_ff.ev_value, rsp_entry_ff.ev_arg, rsp_entry_ff.ev_kind,
                        rsp_entry_ff.ev_time, rsp_cursor_ff, rsp_count_ff};

endmodule

// File: sv/setl_store.sv
// Event store: one write port, one registered read port.
`timescale 1ns / 1ps

module setl_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  setl_pkg::setl_entry_type wr_data,
   input  logic [AW-1:0]           rd_addr,
   output setl_pkg::setl_entry_type rd_data
);

   setl_pkg::setl_entry_type mem [DEPTH];
   setl_pkg::setl_entry_type rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/setl_checker.sv
// Port-level checks on the sorted event timeline, bound to its top level.
`timescale 1ns / 1ps

module setl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic [setl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                      rsp_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);

   // No result is offered straight after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // A stalled result holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // An insert never also returns an entry
   a_stored_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("stored and entry_valid both set");

   // Entry fields are zero unless an entry was read
   a_entry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[87:14] == 74'd0)
      else $error("entry fields set without a valid entry");

endmodule

bind sorted_event_timeline_top setl_checker u_setl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
